@@ src/gdau_pkg.sv @@
// Shared constants, types and calendar tables for the Gregorian date unit.
// No dependencies; imported by gdau_year_unit and gregorian_date_arithmetic_unit.
package gdau_pkg;

	localparam int unsigned MAX_YEAR = 9999;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int OFS_W  = 21;
	localparam int ORD_W  = 23;
	localparam int WD_W   = 3;
	localparam int DBM_W  = 9;

	localparam int unsigned DAYS_YEAR = 365;

	// ordinal of 31/12/MAX_YEAR
	localparam int unsigned LAST_ORD = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400;

	// floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
	localparam int unsigned RECIP_100    = 5243;
	localparam int          RECIP_100_W  = 13;
	localparam int          RECIP_100_SH = 19;
	localparam int          Q100_W       = 8;

	// year estimate: (n - 1) * 400 / 146097 ~ ((n - 1) * 45925) >> 24
	localparam int unsigned YEAR_RECIP    = 45925;
	localparam int          YEAR_RECIP_W  = 16;
	localparam int          YEAR_RECIP_SH = 24;

	localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic             leap;
		logic [ORD_W-1:0] dby;   // days in years 1 .. year-1
	} yu_res_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days of the year before the first of month m; nonsense months give 0
	function automatic logic [DBM_W-1:0] days_before_month(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DBM_W-1:0] base;
		unique case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && m > MONTH_FEB && m <= MONTH_DEC) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

@@ src/gdau_year_unit.sv @@
// Shared year unit: leap flag and days before a given year, registered after stage 2.
// Depends on gdau_pkg.
module gdau_year_unit (
	input  logic                         clk,
	input  logic [gdau_pkg::YEAR_W-1:0]  year,
	output gdau_pkg::yu_res_t            res
);
	import gdau_pkg::*;

	localparam int PROD_W = YEAR_W + RECIP_100_W;
	localparam int HUND_W = Q100_W + 7;

	logic [YEAR_W-1:0] p;
	logic [PROD_W-1:0] prod_y;
	logic [PROD_W-1:0] prod_p;
	logic [ORD_W-1:0]  p365;

	logic [YEAR_W-1:0] y_s1;
	logic [YEAR_W-1:0] p_s1;
	logic [Q100_W-1:0] qy_s1;
	logic [Q100_W-1:0] qp_s1;
	logic [ORD_W-1:0]  p365_s1;

	logic [HUND_W-1:0] hund;
	logic              leap;
	logic [ORD_W-1:0]  dby;
	yu_res_t           res_s2;

	// stage 1: quotients by 100 through reciprocal, 365 * (year - 1)
	always_comb begin
		p      = year - YEAR_W'(1);
		prod_y = PROD_W'(year) * PROD_W'(RECIP_100);
		prod_p = PROD_W'(p) * PROD_W'(RECIP_100);
		p365   = ORD_W'(p) * ORD_W'(DAYS_YEAR);
	end

	always_ff @(posedge clk) begin
		y_s1    <= year;
		p_s1    <= p;
		qy_s1   <= prod_y[RECIP_100_SH +: Q100_W];
		qp_s1   <= prod_p[RECIP_100_SH +: Q100_W];
		p365_s1 <= p365;
	end

	// stage 2: leap test and day count
	always_comb begin
		hund = HUND_W'(qy_s1) * HUND_W'(100);
		leap = (y_s1[1:0] == 2'b00) && ((HUND_W'(y_s1) != hund) || (qy_s1[1:0] == 2'b00));
		dby  = p365_s1 + ORD_W'(p_s1 >> 2) - ORD_W'(qp_s1) + ORD_W'(qp_s1 >> 2);
	end

	always_ff @(posedge clk) begin
		res_s2.leap <= leap;
		res_s2.dby  <= dby;
	end

	assign res = res_s2;

endmodule

@@ src/gregorian_date_arithmetic_unit.sv @@
// Gregorian date unit top level: stream ports, sequencer and result register.
// Depends on gdau_pkg and gdau_year_unit.
//
// Each input item carries two Gregorian dates and a signed day offset; one result item
// comes back with the first date moved by the offset, the day difference (first minus
// second, counted from 1/1/1 as day 1) and the weekday of the first date (0 = Saturday
// .. 6 = Friday). A date outside year 1..MAX_YEAR, month 1..12 or the month's length
// sets date_invalid and zeroes everything else. A shifted date before 1/1/1 or after
// 31/12/MAX_YEAR sets range_error and zeroes the shifted date only. One item is in
// work at a time and s_tready is low meanwhile. A malformed date ends the item after
// the date lookups, a shift out of range ends it at the check, and otherwise the year
// search takes one more lookup per year the reciprocal year estimate falls short (at
// most four) and the month walk one step per month past January (at most eleven).
// The shared year unit is looked up twice for the dates, two to six times in the year
// search. The result register lets the next item be taken while a result still waits
// on m_tready; a second finished result holds the sequencer until the first is taken.
module gregorian_date_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_day, first_month, first_year, second_day, second_month, second_year,
	// day_offset; zero padded
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// shifted_day, shifted_month, shifted_year, day_difference, weekday; zero padded
	output logic [55:0] m_tdata,
	// range_error, date_invalid
	output logic [1:0]  m_tuser
);
	import gdau_pkg::*;

	localparam int TGT_W  = ORD_W + 1;
	localparam int PROD_W = ORD_W + YEAR_RECIP_W;
	localparam int RES_W  = DAY_W + MON_W + YEAR_W + ORD_W + WD_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_ORD1,
		ST_ORD2,
		ST_CHK,
		ST_EST,
		ST_EST2,
		ST_DOWN,
		ST_UP,
		ST_MON,
		ST_DONE
	} state_t;

	// (v mod 7) by folding octal digits, as 8 = 1 mod 7
	function automatic logic [WD_W-1:0] mod7(input logic [ORD_W-1:0] v);
		logic [ORD_W:0] ve;
		logic [5:0]     s;
		logic [3:0]     t;
		ve = {1'b0, v};
		s  = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(ve[3*i +: 3]);
		end
		t = 4'(s[2:0]) + 4'(s[5:3]);
		if (t >= 4'd14) begin
			t = t - 4'd14;
		end else if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[WD_W-1:0];
	endfunction

	state_t state_q;
	state_t ret_q;
	logic   wait_q;

	logic [DAY_W-1:0]  d1_q, d2_q;
	logic [MON_W-1:0]  m1_q, m2_q;
	logic [YEAR_W-1:0] y1_q, y2_q;
	logic [OFS_W-1:0]  k_q;

	logic [YEAR_W-1:0] yu_year_q;
	yu_res_t           yu;

	logic [ORD_W-1:0]  n1_q;
	logic              val1_q;
	logic [ORD_W-1:0]  n_q;
	logic [PROD_W-1:0] prod_q;
	logic [YEAR_W-1:0] yy_q;
	logic [ORD_W-1:0]  dlo_q;
	logic              leaplo_q;
	logic [MON_W-1:0]  mon_q;

	logic [DAY_W-1:0]  sd_q;
	logic [MON_W-1:0]  sm_q;
	logic [YEAR_W-1:0] sy_q;
	logic [ORD_W-1:0]  diff_q;
	logic [WD_W-1:0]   wd_q;
	logic              rerr_q;
	logic              inv_q;

	logic              m_tvalid_q;
	logic [55:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	// date check and ordinal of whichever date the year unit has just served
	logic [DAY_W-1:0]  cd;
	logic [MON_W-1:0]  cm;
	logic [YEAR_W-1:0] cy;
	logic              cval;
	logic [ORD_W-1:0]  cord;

	logic [TGT_W-1:0]  target;
	logic              tgt_bad;
	logic [YEAR_W-1:0] est;
	logic [DAY_W-1:0]  mlen;

	gdau_year_unit u_year (
		.clk  (clk),
		.year (yu_year_q),
		.res  (yu)
	);

	always_comb begin
		if (state_q == ST_ORD1) begin
			cd = d1_q;
			cm = m1_q;
			cy = y1_q;
		end else begin
			cd = d2_q;
			cm = m2_q;
			cy = y2_q;
		end
		cval = (cy != '0) && (cy <= YEAR_W'(MAX_YEAR)) && (cm >= MONTH_JAN)
			&& (cm <= MONTH_DEC) && (cd != '0) && (cd <= month_len(cm, yu.leap));
		cord = yu.dby + ORD_W'(days_before_month(cm, yu.leap)) + ORD_W'(cd);
	end

	always_comb begin
		target  = TGT_W'(n1_q) + {{(TGT_W - OFS_W){k_q[OFS_W-1]}}, k_q};
		tgt_bad = target[TGT_W-1] || (target == '0) || (target > TGT_W'(LAST_ORD));
		est     = prod_q[YEAR_RECIP_SH +: YEAR_W] + YEAR_W'(1);
		mlen    = month_len(mon_q, leaplo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			wait_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			d1_q       <= '0;
			m1_q       <= '0;
			y1_q       <= '0;
			d2_q       <= '0;
			m2_q       <= '0;
			y2_q       <= '0;
			k_q        <= '0;
			yu_year_q  <= '0;
			n1_q       <= '0;
			val1_q     <= 1'b0;
			n_q        <= '0;
			prod_q     <= '0;
			yy_q       <= '0;
			dlo_q      <= '0;
			leaplo_q   <= 1'b0;
			mon_q      <= '0;
			sd_q       <= '0;
			sm_q       <= '0;
			sy_q       <= '0;
			diff_q     <= '0;
			wd_q       <= '0;
			rerr_q     <= 1'b0;
			inv_q      <= 1'b0;
		end else begin
			// in ST_DONE the result register is reloaded instead
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						d1_q      <= s_tdata[4:0];
						m1_q      <= s_tdata[8:5];
						y1_q      <= s_tdata[22:9];
						d2_q      <= s_tdata[27:23];
						m2_q      <= s_tdata[31:28];
						y2_q      <= s_tdata[45:32];
						k_q       <= s_tdata[66:46];
						yu_year_q <= s_tdata[22:9];
						wait_q    <= 1'b1;
						ret_q     <= ST_ORD1;
						state_q   <= ST_WAIT;
					end
				end
				// year unit latency
				ST_WAIT: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_ORD1: begin
					n1_q      <= cord;
					val1_q    <= cval;
					yu_year_q <= y2_q;
					wait_q    <= 1'b1;
					ret_q     <= ST_ORD2;
					state_q   <= ST_WAIT;
				end
				ST_ORD2: begin
					n_q <= cord;
					if (!(val1_q && cval)) begin
						sd_q    <= '0;
						sm_q    <= '0;
						sy_q    <= '0;
						diff_q  <= '0;
						wd_q    <= '0;
						rerr_q  <= 1'b0;
						inv_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CHK;
					end
				end
				// difference, weekday (1/1/1 is a Monday) and the target ordinal
				ST_CHK: begin
					diff_q <= n1_q - n_q;
					wd_q   <= mod7(n1_q + ORD_W'(1));
					inv_q  <= 1'b0;
					sd_q   <= '0;
					sm_q   <= '0;
					sy_q   <= '0;
					n_q    <= target[ORD_W-1:0];
					rerr_q <= tgt_bad;
					if (tgt_bad) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_EST;
					end
				end
				ST_EST: begin
					prod_q  <= PROD_W'(n_q - ORD_W'(1)) * PROD_W'(YEAR_RECIP);
					state_q <= ST_EST2;
				end
				ST_EST2: begin
					yy_q      <= est;
					yu_year_q <= est;
					wait_q    <= 1'b1;
					ret_q     <= ST_DOWN;
					state_q   <= ST_WAIT;
				end
				// step down while the year starts after the target
				ST_DOWN: begin
					wait_q  <= 1'b1;
					state_q <= ST_WAIT;
					if (yy_q > YEAR_W'(1) && yu.dby >= n_q) begin
						yy_q      <= yy_q - YEAR_W'(1);
						yu_year_q <= yy_q - YEAR_W'(1);
						ret_q     <= ST_DOWN;
					end else begin
						dlo_q     <= yu.dby;
						leaplo_q  <= yu.leap;
						yu_year_q <= yy_q + YEAR_W'(1);
						ret_q     <= ST_UP;
					end
				end
				// step up while the next year still starts on or before the target
				ST_UP: begin
					if (yu.dby < n_q) begin
						yy_q      <= yy_q + YEAR_W'(1);
						dlo_q     <= yu.dby;
						leaplo_q  <= yu.leap;
						yu_year_q <= yy_q + YEAR_W'(2);
						wait_q    <= 1'b1;
						ret_q     <= ST_UP;
						state_q   <= ST_WAIT;
					end else begin
						n_q     <= n_q - dlo_q;
						mon_q   <= MONTH_JAN;
						state_q <= ST_MON;
					end
				end
				// one month per cycle through the day of year
				ST_MON: begin
					if (n_q <= ORD_W'(mlen) || mon_q >= MONTH_DEC) begin
						sd_q    <= n_q[DAY_W-1:0];
						sm_q    <= mon_q;
						sy_q    <= yy_q;
						state_q <= ST_DONE;
					end else begin
						n_q   <= n_q - ORD_W'(mlen);
						mon_q <= mon_q + MON_W'(1);
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(56 - RES_W)'(0), wd_q, diff_q, sy_q, sm_q, sd_q};
						m_tuser_q  <= {inv_q, rerr_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ tb/tb_gregorian_date_arithmetic_unit.sv @@
// Self-checking testbench for gregorian_date_arithmetic_unit: a directed set of
// calendar edge cases, then random date pairs and offsets, checked by its own model.
// Depends on gdau_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic_unit;

	import gdau_pkg::*;

	// one input item, unpacked
	typedef struct {
		logic        [DAY_W-1:0]  d1;
		logic        [MON_W-1:0]  m1;
		logic        [YEAR_W-1:0] y1;
		logic        [DAY_W-1:0]  d2;
		logic        [MON_W-1:0]  m2;
		logic        [YEAR_W-1:0] y2;
		logic signed [OFS_W-1:0]  ofs;
		bit                       drain_first; // sender waits for every result before offering
	} date_req_t;

	// one result item, unpacked
	typedef struct {
		logic        [DAY_W-1:0]  sday;
		logic        [MON_W-1:0]  smon;
		logic        [YEAR_W-1:0] syear;
		logic signed [ORD_W-1:0]  diff;
		logic        [WD_W-1:0]   wday;
		logic                     range_err;
		logic                     bad_date;
	} date_res_t;

	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	localparam int IDLE_LIMIT   = 4000; // cycles with no handshake on either side
	localparam int LONG_HOLD    = 300;  // receiver hold-off that backs up the unit
	localparam int SETTLE       = 64;   // quiet time after the last result before finishing
	localparam int RANDOM_ITEMS = 730;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	gregorian_date_arithmetic_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	date_req_t pending_dates[$];   // items still to be offered
	date_res_t expected_dates[$];  // predictions awaiting their result item

	int  errors        = 0;
	int  total_items   = 0;
	int  items_taken   = 0;
	int  results_seen  = 0;
	int  idle_cycles   = 0;
	bit  took          = 1'b0;     // input handshake at the last rising edge

	// sender burst state
	int  burst_left = 0;
	int  gap_left   = 0;

	// receiver stall state
	rx_mode_t rx_mode     = RX_OPEN;
	int       phase_left  = 0;
	int       hold_left   = 0;
	int       rx_tick     = 0;
	bit       long_hold_done = 1'b0;

	// ---------------------------------------------------------------- calendar model

	function automatic bit leap(input longint y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic longint month_days(input longint m, input longint y);
		if (m == 2) return leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	// days in whole years 1 .. y-1
	function automatic longint days_to_year(input longint y);
		longint p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic bit real_date(input longint d, input longint m, input longint y);
		if (y < 1 || y > longint'(MAX_YEAR)) return 1'b0;
		if (m < 1 || m > 12) return 1'b0;
		return d >= 1 && d <= month_days(m, y);
	endfunction

	// day number counted from 1/1/1 as day 1
	function automatic longint day_number(input longint d, input longint m, input longint y);
		longint n;
		n = days_to_year(y) + d;
		for (longint i = 1; i < m; i++) n += month_days(i, y);
		return n;
	endfunction

	function automatic date_res_t shift_and_compare(input date_req_t r);
		date_res_t res;
		longint    n1, n2, target, yy, mm, zm, zy;
		res = '{default: '0};
		if (!real_date(longint'(r.d1), longint'(r.m1), longint'(r.y1))
			|| !real_date(longint'(r.d2), longint'(r.m2), longint'(r.y2))) begin
			res.bad_date = 1'b1;
			return res;
		end
		n1 = day_number(longint'(r.d1), longint'(r.m1), longint'(r.y1));
		n2 = day_number(longint'(r.d2), longint'(r.m2), longint'(r.y2));
		res.diff = ORD_W'(n1 - n2);

		// Zeller: January and February count as months 13 and 14 of the year before
		zm = longint'(r.m1);
		zy = longint'(r.y1);
		if (zm < 3) begin
			zm += 12;
			zy -= 1;
		end
		res.wday = WD_W'((longint'(r.d1) + (13 * (zm + 1)) / 5 + zy + zy / 4 - zy / 100
			+ zy / 400) % 7);

		target = n1 + longint'(r.ofs);
		if (target < 1 || target > days_to_year(longint'(MAX_YEAR) + 1)) begin
			res.range_err = 1'b1;
			return res;
		end
		// estimate the year, then correct it both ways
		yy = ((target - 1) * 400) / 146097 + 1;
		while (yy > 1 && days_to_year(yy) >= target) yy--;
		while (days_to_year(yy + 1) < target) yy++;
		target -= days_to_year(yy);
		mm = 1;
		while (mm < 12 && target > month_days(mm, yy)) begin
			target -= month_days(mm, yy);
			mm++;
		end
		res.sday  = DAY_W'(target);
		res.smon  = MON_W'(mm);
		res.syear = YEAR_W'(yy);
		return res;
	endfunction

	// ---------------------------------------------------------------- packing

	// tdata, lowest bits first: d1, m1, y1, d2, m2, y2, offset, zero pad
	function automatic logic [71:0] pack_dates(input date_req_t r);
		return {5'b0, r.ofs, r.y2, r.m2, r.d2, r.y1, r.m1, r.d1};
	endfunction

	function automatic date_req_t unpack_dates(input logic [71:0] v);
		date_req_t r;
		r.d1  = v[4:0];
		r.m1  = v[8:5];
		r.y1  = v[22:9];
		r.d2  = v[27:23];
		r.m2  = v[31:28];
		r.y2  = v[45:32];
		r.ofs = v[66:46];
		r.drain_first = 1'b0;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	task automatic add_dates(input int d1, input int m1, input int y1, input int d2,
		input int m2, input int y2, input int ofs, input bit drain_first = 1'b0);
		date_req_t r;
		r.d1  = DAY_W'(d1);
		r.m1  = MON_W'(m1);
		r.y1  = YEAR_W'(y1);
		r.d2  = DAY_W'(d2);
		r.m2  = MON_W'(m2);
		r.y2  = YEAR_W'(y2);
		r.ofs = OFS_W'(ofs);
		r.drain_first = drain_first;
		pending_dates.push_back(r);
		total_items++;
	endtask

	// a real date; about one in five lands in the first or last three years
	task automatic pick_date(output int d, output int m, output int y);
		case ($urandom_range(0, 9))
			0:       y = $urandom_range(1, 3);
			1:       y = $urandom_range(int'(MAX_YEAR) - 2, int'(MAX_YEAR));
			default: y = $urandom_range(1, int'(MAX_YEAR));
		endcase
		m = $urandom_range(1, 12);
		// lean on month ends, where carries happen
		if ($urandom_range(0, 3) == 0) d = int'(month_days(longint'(m), longint'(y)));
		else d = $urandom_range(1, int'(month_days(longint'(m), longint'(y))));
	endtask

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------- clock, reset, stimulus

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int d1, m1, y1, d2, m2, y2, ofs;

		// directed: day 1 and the last day, both ways over the edges of the range
		add_dates(1, 1, 1, 1, 1, 1, 0);
		add_dates(1, 1, 1, 1, 1, 1, -1);                   // shift falls before 1/1/1
		add_dates(2, 1, 1, 5, 6, 7, -1);                   // lands exactly on 1/1/1
		add_dates(31, 12, 9999, 1, 1, 1, 1);               // past the last day; largest gap
		add_dates(1, 1, 9999, 31, 12, 9999, 364);          // lands exactly on the last day
		add_dates(1, 1, 1, 31, 12, 9999, 1048575);         // largest forward offset
		add_dates(31, 12, 9999, 1, 1, 1, -1048576);        // largest backward offset
		add_dates(15, 7, 5000, 3, 3, 3000, -1048576);
		// leap years: the 400 rule, the 100 rule, plain fours
		add_dates(29, 2, 2000, 1, 1, 2000, 365);
		add_dates(29, 2, 1900, 1, 1, 1900, 0);             // not a leap year
		add_dates(1, 3, 2024, 29, 2, 2024, -1);            // step back into a leap day
		add_dates(28, 2, 2023, 1, 3, 2023, 1);
		add_dates(31, 12, 1999, 1, 1, 2000, 1);            // year carry forward
		add_dates(1, 1, 2000, 31, 12, 1999, -1);           // year borrow backward
		add_dates(31, 1, 2023, 30, 4, 2023, -400);
		// malformed dates in either position
		add_dates(31, 4, 2023, 1, 1, 2023, 5);             // day past the month's end
		add_dates(0, 5, 2023, 1, 1, 2023, 5);
		add_dates(10, 0, 2023, 1, 1, 2023, 5);
		add_dates(10, 13, 2023, 1, 1, 2023, 5);
		add_dates(1, 1, 2023, 10, 15, 2023, 5);
		add_dates(1, 1, 0, 1, 1, 2023, 5);
		add_dates(1, 1, 2023, 1, 1, 10000, 5);
		add_dates(31, 15, 16383, 31, 15, 16383, -1);       // every field bit set

		// random part, with a full drain before the first and every 150th item
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick_date(d1, m1, y1);
			pick_date(d2, m2, y2);
			case ($urandom_range(0, 19))
				0, 1, 2:           ofs = $urandom_range(0, 62) - 31;
				3, 4, 5, 6, 7, 8, 9: ofs = $urandom_range(0, 800) - 400;
				10, 11, 12, 13, 14: ofs = $urandom_range(0, 80000) - 40000;
				default:           ofs = $urandom_range(0, 2097151) - 1048576;
			endcase
			// now and then spoil one field with a raw value over its whole width
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 5))
					0: d1 = $urandom_range(0, 31);
					1: m1 = $urandom_range(0, 15);
					2: y1 = $urandom_range(0, 16383);
					3: d2 = $urandom_range(0, 31);
					4: m2 = $urandom_range(0, 15);
					default: y2 = $urandom_range(0, 16383);
				endcase
			end
			add_dates(d1, m1, y1, d2, m2, y2, ofs, i % 150 == 0);
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken < total_items) @(posedge clk);
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// ---------------------------------------------------------------- driver
	// Offers items in bursts. s_tvalid and s_tdata get one assignment per edge; a taken
	// item is replaced in place when the burst goes on, so valid never dips.
	always @(negedge clk) begin
		logic        nxt_valid;
		logic [71:0] nxt_data;
		nxt_valid = s_tvalid;
		nxt_data  = s_tdata;
		if (arst_n) begin
			if (took) nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_dates.size() != 0 && !(pending_dates[0].drain_first &&
					(expected_dates.size() != 0 || m_tvalid))) begin
					if (burst_left == 0) burst_left = $urandom_range(1, 24);
					nxt_valid = 1'b1;
					nxt_data  = pack_dates(pending_dates.pop_front());
					burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 1) == 0) gap_left = $urandom_range(0, 2);
						else gap_left = $urandom_range(3, 20);
					end
				end
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata  <= nxt_data;
	end

	// ---------------------------------------------------------------- receiver
	// Stall pattern changes with each phase of random length; once, after some results
	// have come, it holds off long enough for the unit to back up and drop s_tready.
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end else begin
				if (phase_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				rx_tick++;
				case (rx_mode)
					RX_OPEN:     rdy = 1'b1;
					RX_HALF:     rdy = 1'($urandom_range(0, 1));
					RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
					RX_PERIODIC: rdy = (rx_tick % 5 < 3);
					default:     rdy = 1'b1;
				endcase
			end
		end
		m_tready <= rdy;
	end

	// ---------------------------------------------------------------- monitor, checker, watchdog
	always @(posedge clk) begin
		date_res_t want, got;
		took = s_tvalid && s_tready;
		if (arst_n) begin
			if (took) begin
				expected_dates.push_back(shift_and_compare(unpack_dates(s_tdata)));
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_dates.size() == 0) begin
					$display("%0t ns: result item with nothing outstanding, expected none, actual %h/%b",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_dates.pop_front();
					got.sday      = m_tdata[4:0];
					got.smon      = m_tdata[8:5];
					got.syear     = m_tdata[22:9];
					got.diff      = m_tdata[45:23];
					got.wday      = m_tdata[48:46];
					got.range_err = m_tuser[0];
					got.bad_date  = m_tuser[1];
					check_field("shifted_day", longint'(want.sday), longint'(got.sday));
					check_field("shifted_month", longint'(want.smon), longint'(got.smon));
					check_field("shifted_year", longint'(want.syear), longint'(got.syear));
					check_field("day_difference", longint'(want.diff), longint'(got.diff));
					check_field("weekday", longint'(want.wday), longint'(got.wday));
					check_field("range_error", longint'(want.range_err),
						longint'(got.range_err));
					check_field("date_invalid", longint'(want.bad_date),
						longint'(got.bad_date));
				end
			end
			if (took || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
src/gdau_pkg.sv
src/gdau_year_unit.sv
src/gregorian_date_arithmetic_unit.sv
tb/tb_gregorian_date_arithmetic_unit.sv
